>>> src/mpbm_pkg.sv
// Package for the multi-pattern byte matcher: codes, controller states,
// command and status structs between controller and datapath. No dependencies.
package mpbm_pkg;

   localparam int MAX_NODES_DEF = 256;

   // Item command codes
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_END    = 3'd1;
   localparam logic [2:0] CMD_BUILD  = 3'd2;
   localparam logic [2:0] CMD_START  = 3'd3;
   localparam logic [2:0] CMD_SCAN   = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_NO_MATCH = 2'd1;
   localparam logic [1:0] ST_MATCH    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [7:0] LEAD_BIT = 8'h80;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH,
      S_INS_RD, S_INS_WT,
      S_BR_RD, S_BR_WT, S_BQ_RD, S_BQ_WT, S_BC_RD, S_BC_WT, S_BF_RD, S_BF_WT,
      S_CH_CHK, S_CH_WT, S_CH_FIN_RD, S_CH_FIN_WT,
      S_SC_CHK, S_PD_RD, S_PD_WT
   } state_type;

   // Strobes from controller to datapath
   typedef struct packed {
      logic clr_step;
      logic capture;
      logic ld_ins;
      logic ins_done;
      logic end_pat;
      logic bld_init;
      logic br_push;
      logic key_inc;
      logic node_cur;
      logic bq_load;
      logic save_child;
      logic fail_start;
      logic chase_step;
      logic bld_link;
      logic start_txt;
      logic scan_init;
      logic scan_step;
      logic scan_done;
      logic rsp_ok;
   } dp_cmd_type;

   // Flags from datapath to controller
   typedef struct packed {
      logic [2:0] cmd;
      logic       child_nz;
      logic       node_zero;
      logic       guard_done;
      logic       tail_full;
      logic       head_lt_tail;
      logic       key_last;
      logic       skip;
      logic       clr_done;
   } dp_stat_type;

   // Remaining bytes of a character from its lead byte (leading ones, min 1, minus 1)
   function automatic logic [2:0] bytes_after_lead(input logic [7:0] lead);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && lead[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      if (n == 4'd0) begin
         return 3'd0;
      end
      return 3'(n - 4'd1);
   endfunction

endpackage

>>> src/mpbm_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module mpbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> src/mpbm_ctrl.sv
// Controller state machine of the matcher: sequences insert, build and scan.
// Depends on mpbm_pkg.
module mpbm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mpbm_pkg::dp_stat_type st,
   output mpbm_pkg::dp_cmd_type  cmd
);
   mpbm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic done;
   logic slot_free;

   // State and handshake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpbm_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == mpbm_pkg::S_IDLE && slot_free);
   assign rsp_valid = rsp_valid_ff;

   // Next state and strobes
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         mpbm_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) begin
               state_in = mpbm_pkg::S_IDLE;
            end
         end
         mpbm_pkg::S_IDLE: begin
            if (req_valid && slot_free) begin
               cmd.capture = 1'b1;
               state_in    = mpbm_pkg::S_DISPATCH;
            end
         end
         mpbm_pkg::S_DISPATCH: begin
            unique case (st.cmd)
               mpbm_pkg::CMD_INSERT: begin
                  cmd.ld_ins = 1'b1;
                  state_in   = mpbm_pkg::S_INS_RD;
               end
               mpbm_pkg::CMD_END: begin
                  cmd.end_pat = 1'b1;
                  cmd.rsp_ok  = 1'b1;
                  state_in    = mpbm_pkg::S_IDLE;
               end
               mpbm_pkg::CMD_BUILD: begin
                  cmd.bld_init = 1'b1;
                  state_in     = mpbm_pkg::S_BR_RD;
               end
               mpbm_pkg::CMD_START: begin
                  cmd.start_txt = 1'b1;
                  cmd.rsp_ok    = 1'b1;
                  state_in      = mpbm_pkg::S_IDLE;
               end
               mpbm_pkg::CMD_SCAN: begin
                  cmd.scan_init = 1'b1;
                  state_in      = mpbm_pkg::S_SC_CHK;
               end
               default: begin
                  cmd.rsp_ok = 1'b1;
                  state_in   = mpbm_pkg::S_IDLE;
               end
            endcase
         end
         mpbm_pkg::S_INS_RD: state_in = mpbm_pkg::S_INS_WT;
         mpbm_pkg::S_INS_WT: begin
            cmd.ins_done = 1'b1;
            state_in     = mpbm_pkg::S_IDLE;
         end
         // children of the root
         mpbm_pkg::S_BR_RD: state_in = mpbm_pkg::S_BR_WT;
         mpbm_pkg::S_BR_WT: begin
            cmd.br_push = st.child_nz && !st.tail_full;
            cmd.key_inc = 1'b1;
            state_in    = st.key_last ? mpbm_pkg::S_BQ_RD : mpbm_pkg::S_BR_RD;
         end
         // breadth-first queue walk
         mpbm_pkg::S_BQ_RD: begin
            if (st.head_lt_tail) begin
               state_in = mpbm_pkg::S_BQ_WT;
            end else begin
               cmd.rsp_ok = 1'b1;
               state_in   = mpbm_pkg::S_IDLE;
            end
         end
         mpbm_pkg::S_BQ_WT: begin
            cmd.bq_load = 1'b1;
            state_in    = mpbm_pkg::S_BC_RD;
         end
         mpbm_pkg::S_BC_RD: state_in = mpbm_pkg::S_BC_WT;
         mpbm_pkg::S_BC_WT: begin
            if (st.child_nz) begin
               cmd.save_child = 1'b1;
               state_in       = mpbm_pkg::S_BF_RD;
            end else begin
               cmd.key_inc = 1'b1;
               state_in    = st.key_last ? mpbm_pkg::S_BQ_RD : mpbm_pkg::S_BC_RD;
            end
         end
         mpbm_pkg::S_BF_RD: state_in = mpbm_pkg::S_BF_WT;
         mpbm_pkg::S_BF_WT: begin
            cmd.fail_start = 1'b1;
            state_in       = mpbm_pkg::S_CH_CHK;
         end
         // failure-link chase, shared by build and scan
         mpbm_pkg::S_CH_CHK: begin
            if (st.node_zero || st.guard_done) begin
               state_in = mpbm_pkg::S_CH_FIN_RD;
            end else begin
               state_in = mpbm_pkg::S_CH_WT;
            end
         end
         mpbm_pkg::S_CH_WT: begin
            if (st.child_nz) begin
               state_in = mpbm_pkg::S_CH_FIN_RD;
            end else begin
               cmd.chase_step = 1'b1;
               state_in       = mpbm_pkg::S_CH_CHK;
            end
         end
         mpbm_pkg::S_CH_FIN_RD: state_in = mpbm_pkg::S_CH_FIN_WT;
         mpbm_pkg::S_CH_FIN_WT: begin
            if (st.cmd == mpbm_pkg::CMD_BUILD) begin
               cmd.bld_link = 1'b1;
               cmd.node_cur = 1'b1;
               cmd.key_inc  = 1'b1;
               state_in     = st.key_last ? mpbm_pkg::S_BQ_RD : mpbm_pkg::S_BC_RD;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = mpbm_pkg::S_PD_RD;
            end
         end
         mpbm_pkg::S_SC_CHK: begin
            state_in = st.skip ? mpbm_pkg::S_PD_RD : mpbm_pkg::S_CH_CHK;
         end
         mpbm_pkg::S_PD_RD: state_in = mpbm_pkg::S_PD_WT;
         mpbm_pkg::S_PD_WT: begin
            cmd.scan_done = 1'b1;
            state_in      = mpbm_pkg::S_IDLE;
         end
         default: state_in = mpbm_pkg::S_IDLE;
      endcase
   end

   // Result slot: filled at the end of an item, emptied when taken
   assign done = cmd.ins_done || cmd.scan_done || cmd.rsp_ok;
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (done) begin
         rsp_valid_in = 1'b1;
      end
   end
endmodule

>>> src/mpbm_dp.sv
// Datapath of the matcher: trie child table, failure links, end flags,
// breadth-first queue and scan registers. Depends on mpbm_pkg and mpbm_ram.
module mpbm_dp #(
   parameter int MAX_NODES = mpbm_pkg::MAX_NODES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_command,
   input  logic [7:0]            req_data_byte,
   input  mpbm_pkg::dp_cmd_type  cmd,
   output mpbm_pkg::dp_stat_type st,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_pattern_node,
   output logic [15:0]           rsp_char_position
);
   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = NW + 8;
   localparam logic [NW:0] MAX_CNT = (NW + 1)'(MAX_NODES);

   // Control registers
   logic [CW-1:0] clr_ff, clr_in;
   logic [NW:0]   nc_ff, nc_in;
   logic [NW-1:0] cursor_ff, cursor_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic [2:0]    left_ff, left_in;
   logic          skip_ff, skip_in;
   logic [15:0]   cc_ff, cc_in;
   logic [NW:0]   head_ff, head_in;
   logic [NW:0]   tail_ff, tail_in;
   logic [NW:0]   guard_ff, guard_in;
   // Working registers
   logic [2:0]    cmd_ff, cmd_in;
   logic [7:0]    byte_ff, byte_in;
   logic [7:0]    key_ff, key_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] child_ff, child_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    pnode_ff, pnode_in;
   logic [15:0]   cpos_ff, cpos_in;

   // RAM ports
   logic          ct_we, fl_we, pe_we, q_we;
   logic [CW-1:0] ct_waddr;
   logic [NW-1:0] ct_wdata, ct_rdata;
   logic [NW-1:0] fl_waddr, fl_wdata, fl_rdata;
   logic [NW-1:0] pe_waddr;
   logic          pe_wdata, pe_rdata;
   logic [NW-1:0] q_wdata, q_rdata;
   logic          nc_full;
   logic [NW+7:0] scan_ext;

   mpbm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * 256)) u_child (
      .clock(clock), .wr_en(ct_we), .wr_addr(ct_waddr), .wr_data(ct_wdata),
      .rd_addr({node_ff, key_ff}), .rd_data(ct_rdata)
   );
   mpbm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
      .clock(clock), .wr_en(fl_we), .wr_addr(fl_waddr), .wr_data(fl_wdata),
      .rd_addr(node_ff), .rd_data(fl_rdata)
   );
   mpbm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_pend (
      .clock(clock), .wr_en(pe_we), .wr_addr(pe_waddr), .wr_data(pe_wdata),
      .rd_addr(scan_ff), .rd_data(pe_rdata)
   );
   mpbm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(tail_ff[NW-1:0]), .wr_data(q_wdata),
      .rd_addr(head_ff[NW-1:0]), .rd_data(q_rdata)
   );

   assign nc_full  = nc_ff == MAX_CNT;
   assign scan_ext = {8'd0, scan_ff};

   // Status towards the controller
   always_comb begin
      st.cmd          = cmd_ff;
      st.child_nz     = ct_rdata != '0;
      st.node_zero    = node_ff == '0;
      st.guard_done   = guard_ff == MAX_CNT;
      st.tail_full    = tail_ff == MAX_CNT;
      st.head_lt_tail = head_ff < tail_ff;
      st.key_last     = key_ff == 8'hFF;
      st.skip         = skip_ff;
      st.clr_done     = clr_ff == '1;
   end

   // Memory writes
   always_comb begin
      ct_we    = 1'b0;
      ct_waddr = {cursor_ff, byte_ff};
      ct_wdata = nc_ff[NW-1:0];
      fl_we    = 1'b0;
      fl_waddr = nc_ff[NW-1:0];
      fl_wdata = '0;
      pe_we    = 1'b0;
      pe_waddr = nc_ff[NW-1:0];
      pe_wdata = 1'b0;
      q_we     = 1'b0;
      q_wdata  = child_ff;
      if (cmd.clr_step) begin
         ct_we    = 1'b1;
         ct_waddr = clr_ff;
         ct_wdata = '0;
         fl_we    = 1'b1;
         fl_waddr = clr_ff[NW-1:0];
         pe_we    = 1'b1;
         pe_waddr = clr_ff[NW-1:0];
      end
      // new trie node
      if (cmd.ins_done && ct_rdata == '0 && !nc_full) begin
         ct_we = 1'b1;
         fl_we = 1'b1;
         pe_we = 1'b1;
      end
      if (cmd.end_pat && cursor_ff != '0) begin
         pe_we    = 1'b1;
         pe_waddr = cursor_ff;
         pe_wdata = 1'b1;
      end
      if (cmd.bld_init) begin
         fl_we    = 1'b1;
         fl_waddr = '0;
      end
      // root child: link to root and queue it
      if (cmd.br_push) begin
         fl_we    = 1'b1;
         fl_waddr = ct_rdata;
         q_we     = 1'b1;
         q_wdata  = ct_rdata;
      end
      if (cmd.bld_link) begin
         fl_we    = 1'b1;
         fl_waddr = child_ff;
         fl_wdata = ct_rdata;
         q_we     = !st.tail_full;
      end
   end

   // Next register values
   always_comb begin
      clr_in    = clr_ff;
      nc_in     = nc_ff;
      cursor_in = cursor_ff;
      scan_in   = scan_ff;
      left_in   = left_ff;
      skip_in   = skip_ff;
      cc_in     = cc_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      guard_in  = guard_ff;
      cmd_in    = cmd_ff;
      byte_in   = byte_ff;
      key_in    = key_ff;
      node_in   = node_ff;
      cur_in    = cur_ff;
      child_in  = child_ff;
      status_in = status_ff;
      pnode_in  = pnode_ff;
      cpos_in   = cpos_ff;
      if (cmd.clr_step) begin
         clr_in = clr_ff + CW'(1);
      end
      if (cmd.capture) begin
         cmd_in  = req_command;
         byte_in = req_data_byte;
      end
      if (cmd.ld_ins) begin
         node_in = cursor_ff;
         key_in  = byte_ff;
      end
      // insert byte: follow, add or report full
      if (cmd.ins_done) begin
         status_in = mpbm_pkg::ST_ACCEPTED;
         pnode_in  = '0;
         cpos_in   = '0;
         if (ct_rdata != '0) begin
            cursor_in = ct_rdata;
         end else if (!nc_full) begin
            cursor_in = nc_ff[NW-1:0];
            nc_in     = nc_ff + (NW + 1)'(1);
         end else begin
            status_in = mpbm_pkg::ST_FULL;
         end
      end
      if (cmd.end_pat) begin
         cursor_in = '0;
      end
      if (cmd.bld_init) begin
         head_in = '0;
         tail_in = '0;
         node_in = '0;
         key_in  = '0;
      end
      if (cmd.br_push || (cmd.bld_link && !st.tail_full)) begin
         tail_in = tail_ff + (NW + 1)'(1);
      end
      if (cmd.br_push) begin
         child_in = ct_rdata;
      end
      if (cmd.key_inc) begin
         key_in = key_ff + 8'd1;
      end
      if (cmd.node_cur) begin
         node_in = cur_ff;
      end
      if (cmd.bq_load) begin
         cur_in  = q_rdata;
         node_in = q_rdata;
         head_in = head_ff + (NW + 1)'(1);
         key_in  = '0;
      end
      if (cmd.save_child) begin
         child_in = ct_rdata;
      end
      if (cmd.fail_start) begin
         node_in  = fl_rdata;
         guard_in = '0;
      end
      if (cmd.chase_step) begin
         node_in  = fl_rdata;
         guard_in = guard_ff + (NW + 1)'(1);
      end
      if (cmd.start_txt) begin
         scan_in = '0;
         left_in = '0;
         skip_in = 1'b0;
         cc_in   = '0;
      end
      // character bookkeeping on a scan byte
      if (cmd.scan_init) begin
         if (left_ff == '0) begin
            left_in = mpbm_pkg::bytes_after_lead(byte_ff);
            skip_in = 1'b0;
         end else begin
            left_in = left_ff - 3'd1;
         end
         node_in  = scan_ff;
         key_in   = byte_ff;
         guard_in = '0;
      end
      if (cmd.scan_step) begin
         if (ct_rdata != '0) begin
            scan_in = ct_rdata;
         end else begin
            scan_in = node_ff;
            skip_in = 1'b1;
         end
      end
      // scan result at character end
      if (cmd.scan_done) begin
         status_in = mpbm_pkg::ST_NO_MATCH;
         pnode_in  = '0;
         cpos_in   = '0;
         if (left_ff == '0) begin
            if (!skip_ff && pe_rdata) begin
               status_in = mpbm_pkg::ST_MATCH;
               pnode_in  = scan_ext[7:0];
               cpos_in   = cc_ff;
            end
            if (cc_ff != 16'hFFFF) begin
               cc_in = cc_ff + 16'd1;
            end
         end
      end
      if (cmd.rsp_ok) begin
         status_in = mpbm_pkg::ST_ACCEPTED;
         pnode_in  = '0;
         cpos_in   = '0;
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         nc_ff     <= (NW + 1)'(1);
         cursor_ff <= '0;
         scan_ff   <= '0;
         left_ff   <= '0;
         skip_ff   <= 1'b0;
         cc_ff     <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         guard_ff  <= '0;
      end else begin
         clr_ff    <= clr_in;
         nc_ff     <= nc_in;
         cursor_ff <= cursor_in;
         scan_ff   <= scan_in;
         left_ff   <= left_in;
         skip_ff   <= skip_in;
         cc_ff     <= cc_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         guard_ff  <= guard_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      byte_ff   <= byte_in;
      key_ff    <= key_in;
      node_ff   <= node_in;
      cur_ff    <= cur_in;
      child_ff  <= child_in;
      status_ff <= status_in;
      pnode_ff  <= pnode_in;
      cpos_ff   <= cpos_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_pattern_node  = pnode_ff;
   assign rsp_char_position = cpos_ff;
endmodule

>>> src/multi_pattern_byte_matcher.sv
// Matcher top level (trie insert, failure-link build, scan); joins mpbm_ctrl and mpbm_dp.
// Items are handled one at a time. Build links the root's children to the root and
// queues them, then gives each child of every queued node its failure link by
// following failure links. After reset a clearing pass empties the child table,
// the failure links and the end flags.
module multi_pattern_byte_matcher #(
   parameter int MAX_NODES = mpbm_pkg::MAX_NODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_pattern_node,
   output logic [15:0] rsp_char_position
);
   mpbm_pkg::dp_cmd_type  dp_cmd;
   mpbm_pkg::dp_stat_type dp_stat;

   mpbm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .st(dp_stat), .cmd(dp_cmd)
   );

   mpbm_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock(clock), .reset(reset),
      .req_command(req_command), .req_data_byte(req_data_byte),
      .cmd(dp_cmd), .st(dp_stat),
      .rsp_status(rsp_status), .rsp_pattern_node(rsp_pattern_node),
      .rsp_char_position(rsp_char_position)
   );
endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the multi-pattern byte matcher: a scoreboard class
// predicts every result from the accepted items. Depends on mpbm_pkg and the RTL.
module tb_top;

   localparam int NODES = mpbm_pkg::MAX_NODES_DEF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = mpbm_pkg::CMD_START;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_pattern_node;
   logic [15:0] rsp_char_position;

   multi_pattern_byte_matcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_pattern_node(rsp_pattern_node),
      .rsp_char_position(rsp_char_position)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Trie and scan state kept alongside the block, plus the results still owed
   class match_scoreboard;
      typedef struct packed {
         logic [1:0]  status;
         logic [7:0]  node;
         logic [15:0] position;
      } match_result_type;

      match_result_type owed[$];
      int errors;
      int kids[NODES*256];
      int fail_to[NODES];
      bit ends_here[NODES];
      int bfs[NODES];
      int node_total, ins_at, scan_at, bytes_left, char_idx;
      bit skipping;

      function new();
         foreach (kids[i]) kids[i] = 0;
         foreach (fail_to[i]) begin
            fail_to[i] = 0;
            ends_here[i] = 1'b0;
         end
         node_total = 1;
         ins_at = 0;
         scan_at = 0;
         bytes_left = 0;
         char_idx = 0;
         skipping = 1'b0;
         errors = 0;
      endfunction

      function int follow(int node, int b);
         int guard;
         guard = 0;
         while (node != 0 && kids[node*256 + b] == 0 && guard < NODES) begin
            node = fail_to[node];
            guard++;
         end
         return node;
      endfunction

      // Breadth-first failure links
      function void link_failures();
         int head, tail, cur, c;
         head = 0;
         tail = 0;
         fail_to[0] = 0;
         for (int b = 0; b < 256; b++) begin
            c = kids[b];
            if (c != 0 && tail < NODES) begin
               fail_to[c] = 0;
               bfs[tail++] = c;
            end
         end
         while (head < tail) begin
            cur = bfs[head++];
            for (int b = 0; b < 256; b++) begin
               c = kids[cur*256 + b];
               if (c != 0) begin
                  fail_to[c] = kids[follow(fail_to[cur], b)*256 + b];
                  if (tail < NODES) bfs[tail++] = c;
               end
            end
         end
      endfunction

      function void note_item(logic [2:0] cmd, logic [7:0] b);
         match_result_type r;
         int n, c, len;
         r = '0;
         case (cmd)
            mpbm_pkg::CMD_INSERT: begin
               c = kids[ins_at*256 + b];
               if (c != 0) begin
                  ins_at = c;
               end else if (node_total < NODES) begin
                  kids[ins_at*256 + b] = node_total;
                  fail_to[node_total] = 0;
                  ends_here[node_total] = 1'b0;
                  ins_at = node_total;
                  node_total++;
               end else begin
                  r.status = mpbm_pkg::ST_FULL;
               end
            end
            mpbm_pkg::CMD_END: begin
               if (ins_at != 0) ends_here[ins_at] = 1'b1;
               ins_at = 0;
            end
            mpbm_pkg::CMD_BUILD: link_failures();
            mpbm_pkg::CMD_START: begin
               scan_at = 0;
               bytes_left = 0;
               skipping = 1'b0;
               char_idx = 0;
            end
            mpbm_pkg::CMD_SCAN: begin
               if (bytes_left == 0) begin
                  len = 0;
                  while (len < 8 && b[7-len]) len++;
                  bytes_left = (len == 0) ? 0 : len - 1;
                  skipping = 1'b0;
               end else begin
                  bytes_left--;
               end
               if (!skipping) begin
                  n = follow(scan_at, b);
                  c = kids[n*256 + b];
                  if (c != 0) begin
                     scan_at = c;
                  end else begin
                     scan_at = n;
                     skipping = 1'b1;
                  end
               end
               r.status = mpbm_pkg::ST_NO_MATCH;
               if (bytes_left == 0) begin
                  if (!skipping && ends_here[scan_at]) begin
                     r.status = mpbm_pkg::ST_MATCH;
                     r.node = scan_at[7:0];
                     r.position = char_idx[15:0];
                  end
                  if (char_idx != 65535) char_idx++;
               end
            end
            default: ;
         endcase
         owed = {owed, r};
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [1:0] st, logic [7:0] nd, logic [15:0] pos);
         match_result_type e;
         if (owed.size() == 0) begin
            report("result with nothing owed");
         end else begin
            e = owed.pop_front();
            if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
            if (nd !== e.node) report($sformatf("node %0d, want %0d", nd, e.node));
            if (pos !== e.position)
               report($sformatf("position %0d, want %0d", pos, e.position));
         end
      endtask
   endclass

   match_scoreboard sb = new();

   // Monitor both channels at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_command, req_data_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_pattern_node, rsp_char_position);
      end
   end

   // Receiver stall: a randomly chosen mode of no, random or periodic stalling
   int stall_mode = 0;
   int stall_count = 0;
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      if (stall_mode == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 9) < 3);
      end else if (stall_mode == 2) begin
         rsp_stall <= (stall_count % 16) < 11;
      end else begin
         rsp_stall <= ($urandom_range(0, 1) == 1);
      end
   end

   int burst_left = 0;

   // Drive one item and wait for it to be taken; gaps fall between bursts
   task send(logic [2:0] cmd, logic [7:0] b);
      int gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Character k of a small alphabet, ASCII and multi-byte
   function automatic void add_char(ref logic [7:0] q[$], input int k);
      case (k)
         0, 1, 2, 3: q = {q, 8'h61 + k[7:0]};
         4: q = {q, 8'hC3, 8'hA9};
         5: q = {q, 8'hE2, 8'h82, 8'hAC};
         default: q = {q, 8'hF0, 8'h9F, 8'h98, 8'h80};
      endcase
   endfunction

   task add_pattern(input logic [7:0] q[$]);
      foreach (q[i]) send(mpbm_pkg::CMD_INSERT, q[i]);
      send(mpbm_pkg::CMD_END, 8'($urandom_range(0, 255)));
   endtask

   task scan_bytes(input logic [7:0] q[$]);
      foreach (q[i]) send(mpbm_pkg::CMD_SCAN, q[i]);
   endtask

   task random_pattern();
      logic [7:0] q[$];
      repeat ($urandom_range(1, 3)) add_char(q, $urandom_range(0, 6));
      add_pattern(q);
   endtask

   initial begin
      logic [7:0] q[$];
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: small patterns, lead byte of all ones, empty pattern, odd commands
      add_pattern('{8'h61, 8'h62});
      add_pattern('{8'h62, 8'h61, 8'h62});
      add_pattern('{8'hC3, 8'hA9});
      add_pattern('{8'hFF, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'hBF});
      send(mpbm_pkg::CMD_END, 8'h00);
      add_pattern('{8'h00, 8'hFF});
      for (int c = mpbm_pkg::CMD_SCAN + 1; c < 8; c++) send(c[2:0], 8'hFF);
      send(mpbm_pkg::CMD_BUILD, 8'h00);
      send(mpbm_pkg::CMD_START, 8'hFF);
      scan_bytes('{8'h62, 8'h61, 8'h62, 8'hC3, 8'hA9, 8'h00, 8'hFF});
      scan_bytes('{8'hFF, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'hBF});
      scan_bytes('{8'hE2, 8'h82});
      send(mpbm_pkg::CMD_START, 8'h00);
      scan_bytes('{8'h7A, 8'h61, 8'h62, 8'hC3, 8'h62});

      // Rounds of new patterns, a rebuild and long random texts
      for (int round = 0; round < 4; round++) begin
         repeat ($urandom_range(2, 4)) random_pattern();
         if (round != 2) send(mpbm_pkg::CMD_BUILD, 8'($urandom_range(0, 255)));
         if (round >= 1) random_pattern();  // inserted after the build
         send(mpbm_pkg::CMD_START, 8'($urandom_range(0, 255)));
         for (int i = 0; i < 260; ) begin
            k = $urandom_range(0, 99);
            q.delete();
            if (k < 80) begin
               add_char(q, $urandom_range(0, 6));
            end else if (k < 92) begin
               q = {q, 8'($urandom_range(0, 255))};
            end else if (k < 95) begin
               add_char(q, 6);
               void'(q.pop_back());  // broken character
            end else if (k < 97) begin
               send(mpbm_pkg::CMD_START, 8'($urandom_range(0, 255)));
            end else begin
               send(3'($urandom_range(mpbm_pkg::CMD_SCAN + 1, 7)),
                    8'($urandom_range(0, 255)));
            end
            scan_bytes(q);
            i += q.size() + 1;
         end
      end

      // Fill the node table, then overflow it
      q.delete();
      repeat (NODES + 4) q = {q, 8'($urandom_range(0, 255))};
      add_pattern(q);
      send(mpbm_pkg::CMD_INSERT, 8'h61);
      send(mpbm_pkg::CMD_INSERT, 8'h5A);
      send(mpbm_pkg::CMD_END, 8'h00);
      send(mpbm_pkg::CMD_BUILD, 8'h00);
      send(mpbm_pkg::CMD_START, 8'h00);
      q.delete();
      repeat (80) add_char(q, $urandom_range(0, 6));
      scan_bytes(q);

      // A known match on a fresh text
      send(mpbm_pkg::CMD_START, 8'h00);
      scan_bytes('{8'h62, 8'h61, 8'h62, 8'hC3, 8'hA9});
      req_valid <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #40000000;
      $display("Verification failed");
      $finish;
   end

endmodule
